// File: src/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("next-cycle check failed");

`endif

// File: src/prp_pkg.sv
package prp_pkg;

	localparam int COORD_FRAC_BITS = 8;
	localparam int TRIG_FRAC_BITS  = 15;

	localparam int FIELD_W   = 24;
	localparam int COORD_W   = 29;
	localparam int TRIG_W    = TRIG_FRAC_BITS + 2;
	localparam int PROD_W    = COORD_W + TRIG_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int ANGLE_W   = 10;
	localparam int SIZE_W    = 10;
	localparam int DEG_W     = 9;
	localparam int TAB_W     = TRIG_FRAC_BITS + 1;
	localparam int TAB_IDX_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_ROT   = 5;
	localparam int PIPE_DEPTH = 2 * NUM_ROT + 1;
	localparam int TRIG_ONE  = 1 << TRIG_FRAC_BITS;
	localparam int ROUND_HALF = 1 << (TRIG_FRAC_BITS - 1);

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint unsigned TAYLOR_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [TRIG_W-1:0]  trig_val_t;
	typedef logic signed [COORD_W:0]   diff_t;

	localparam diff_t SAT_HI = diff_t'((1 << (FIELD_W - 1)) - 1);
	localparam diff_t SAT_LO = diff_t'(-(1 << (FIELD_W - 1)));

	typedef struct packed {
		field_t point_x;
		field_t point_y;
		field_t point_z;
		field_t depth_offset;
	} point_t;

	typedef struct packed {
		field_t proj_x;
		field_t proj_y;
	} proj_t;

	typedef struct packed {
		trig_val_t sin_v;
		trig_val_t cos_v;
	} trig_t;

	typedef struct packed {
		trig_t  part_yaw;
		trig_t  part_pitch;
		trig_t  view_yaw;
		trig_t  view_pitch;
		trig_t  view_roll;
		coord_t half_size;
		field_t origin_x;
		field_t origin_y;
	} cfg_t;

	typedef struct packed {
		coord_t u;
		coord_t v;
		coord_t off_u;
		coord_t off_v;
		coord_t k0;
		coord_t k1;
	} rot_in_t;

	typedef struct packed {
		coord_t u;
		coord_t v;
		coord_t k0;
		coord_t k1;
	} rot_out_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VIEW_YAW,
		CFG_VIEW_PITCH,
		CFG_VIEW_ROLL,
		CFG_PART_YAW,
		CFG_PART_PITCH,
		CFG_PART_SIZE,
		CFG_ORIGIN_X,
		CFG_ORIGIN_Y
	} cfg_reg_t;

	localparam trig_t TRIG_ZERO_ANGLE = '{sin_v: trig_val_t'(0), cos_v: trig_val_t'(TRIG_ONE)};

	localparam cfg_t CFG_RESET = '{
		part_yaw:   TRIG_ZERO_ANGLE,
		part_pitch: TRIG_ZERO_ANGLE,
		view_yaw:   TRIG_ZERO_ANGLE,
		view_pitch: TRIG_ZERO_ANGLE,
		view_roll:  TRIG_ZERO_ANGLE,
		half_size:  coord_t'(0),
		origin_x:   field_t'(0),
		origin_y:   field_t'(0)
	};

	// sin(0..90 deg): Taylor series in Q30, rounded to the trig format
	function automatic logic [90:0][TAB_W-1:0] build_sin_tab();
		logic [90:0][TAB_W-1:0] tab;
		longint unsigned x;
		longint unsigned t;
		longint s;
		tab = '0;
		for (int k = 0; k <= 90; k++) begin
			x = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
			t = x;
			s = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				t = (t * x) >> 30;
				t = (t * x) >> 30;
				t = t / TAYLOR_DIV[n];
				if (n % 2 == 1) begin
					s = s - longint'(t);
				end else begin
					s = s + longint'(t);
				end
			end
			if (s < 0) begin
				s = 0;
			end
			tab[k] = TAB_W'((longint'(s) + (64'd1 << (29 - TRIG_FRAC_BITS)))
				>> (30 - TRIG_FRAC_BITS));
		end
		return tab;
	endfunction

	localparam logic [90:0][TAB_W-1:0] SIN_TAB = build_sin_tab();

	function automatic logic [DEG_W-1:0] reduce_deg(input logic signed [ANGLE_W-1:0] a);
		logic signed [ANGLE_W+1:0] w;
		w = (ANGLE_W+2)'(a);
		if (w < -360) begin
			w = w + (ANGLE_W+2)'(720);
		end else if (w < 0) begin
			w = w + (ANGLE_W+2)'(360);
		end else if (w >= 360) begin
			w = w - (ANGLE_W+2)'(360);
		end
		return w[DEG_W-1:0];
	endfunction

	function automatic trig_val_t sin_deg(input logic [DEG_W-1:0] a);
		logic [TAB_IDX_W-1:0] idx;
		logic neg;
		trig_val_t mag;
		if (a <= DEG_W'(90)) begin
			idx = a[TAB_IDX_W-1:0];
			neg = 1'b0;
		end else if (a <= DEG_W'(180)) begin
			idx = TAB_IDX_W'(DEG_W'(180) - a);
			neg = 1'b0;
		end else if (a <= DEG_W'(270)) begin
			idx = TAB_IDX_W'(a - DEG_W'(180));
			neg = 1'b1;
		end else begin
			idx = TAB_IDX_W'(DEG_W'(360) - a);
			neg = 1'b1;
		end
		mag = trig_val_t'({1'b0, SIN_TAB[idx]});
		return neg ? -mag : mag;
	endfunction

	function automatic trig_t trig_of(input logic signed [ANGLE_W-1:0] a);
		logic [DEG_W-1:0] d;
		logic [DEG_W-1:0] dc;
		trig_t r;
		d = reduce_deg(a);
		dc = d + DEG_W'(90);
		if (dc >= DEG_W'(360)) begin
			dc = dc - DEG_W'(360);
		end
		r.sin_v = sin_deg(d);
		r.cos_v = sin_deg(dc);
		return r;
	endfunction

	function automatic field_t sat_field(input diff_t v);
		if (v > SAT_HI) begin
			return field_t'(SAT_HI);
		end else if (v < SAT_LO) begin
			return field_t'(SAT_LO);
		end
		return field_t'(v);
	endfunction

endpackage

// File: src/prp_cfg.sv
module prp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [prp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [prp_pkg::FIELD_W-1:0]   cfg_wdata,
	output prp_pkg::cfg_t                 cfg
);
	import prp_pkg::*;

	cfg_t cfg_q;
	trig_t wr_trig;
	logic [SIZE_W+COORD_FRAC_BITS-1:0] size_fx;
	coord_t wr_half;

	// sin/cos resolved at write time, kept off the datapath
	always_comb begin
		wr_trig = trig_of(cfg_wdata[ANGLE_W-1:0]);
		size_fx = (SIZE_W+COORD_FRAC_BITS)'(cfg_wdata[SIZE_W-1:0]) << COORD_FRAC_BITS;
		wr_half = -coord_t'(size_fx >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				CFG_VIEW_YAW:   cfg_q.view_yaw   <= wr_trig;
				CFG_VIEW_PITCH: cfg_q.view_pitch <= wr_trig;
				CFG_VIEW_ROLL:  cfg_q.view_roll  <= wr_trig;
				CFG_PART_YAW:   cfg_q.part_yaw   <= wr_trig;
				CFG_PART_PITCH: cfg_q.part_pitch <= wr_trig;
				CFG_PART_SIZE:  cfg_q.half_size  <= wr_half;
				CFG_ORIGIN_X:   cfg_q.origin_x   <= cfg_wdata;
				CFG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_wdata;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/prp_rot.sv
module prp_rot (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              feed_valid,
	output logic              feed_stall,
	input  prp_pkg::rot_in_t  feed,
	input  prp_pkg::trig_t    trig,
	output logic              res_valid,
	input  logic              res_stall,
	output prp_pkg::rot_out_t res
);
	import prp_pkg::*;

	logic valid_s1;
	logic valid_s2;
	logic adv_s1;
	logic adv_s2;

	logic signed [PROD_W-1:0] p_uc_s1;
	logic signed [PROD_W-1:0] p_vs_s1;
	logic signed [PROD_W-1:0] p_us_s1;
	logic signed [PROD_W-1:0] p_vc_s1;
	coord_t off_u_s1;
	coord_t off_v_s1;
	coord_t k0_s1;
	coord_t k1_s1;

	logic signed [SUM_W-1:0] sum_u;
	logic signed [SUM_W-1:0] sum_v;
	logic signed [SUM_W-1:0] rnd_u;
	logic signed [SUM_W-1:0] rnd_v;
	rot_out_t res_nxt;
	rot_out_t res_s2;

	assign adv_s2 = !valid_s2 || !res_stall;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign feed_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= feed_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage 1: four products
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			p_uc_s1  <= feed.u * trig.cos_v;
			p_vs_s1  <= feed.v * trig.sin_v;
			p_us_s1  <= feed.u * trig.sin_v;
			p_vc_s1  <= feed.v * trig.cos_v;
			off_u_s1 <= feed.off_u;
			off_v_s1 <= feed.off_v;
			k0_s1    <= feed.k0;
			k1_s1    <= feed.k1;
		end
	end

	// stage 2: sums, round half up, add offsets
	always_comb begin
		sum_u = SUM_W'(p_uc_s1) - SUM_W'(p_vs_s1) + SUM_W'(ROUND_HALF);
		sum_v = SUM_W'(p_us_s1) + SUM_W'(p_vc_s1) + SUM_W'(ROUND_HALF);
		rnd_u = sum_u >>> TRIG_FRAC_BITS;
		rnd_v = sum_v >>> TRIG_FRAC_BITS;
		res_nxt.u  = coord_t'(rnd_u) + off_u_s1;
		res_nxt.v  = coord_t'(rnd_v) + off_v_s1;
		res_nxt.k0 = k0_s1;
		res_nxt.k1 = k1_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_valid = valid_s2;
	assign res = res_s2;

endmodule

// File: src/point_rotate_project_unit.sv
// Rotates a 3D point (Q15.8) plus a part offset of half the part size and the given depth,
// first by the part yaw and pitch, then by the view yaw, pitch and roll, subtracts the origin
// and returns the saturated 2D position. One point is taken per clock unless point_stall is
// high; each point passes through five rotators of two stages each (products, then
// round and add) and one saturating output stage. A stalled output holds only the stages
// behind it that are full, so points keep entering until the bubbles are used up. Angle
// writes look up sin/cos at the write itself; the user must write registers only while
// the block holds no point, which the block itself does not enforce.
module point_rotate_project_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [prp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [prp_pkg::FIELD_W-1:0]   cfg_wdata,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  prp_pkg::point_t               point,
	output logic                          proj_valid,
	input  logic                          proj_stall,
	output prp_pkg::proj_t                proj
);
	import prp_pkg::*;

	cfg_t cfg;

	rot_in_t  r1_in, r2_in, r3_in, r4_in, r5_in;
	rot_out_t r1_out, r2_out, r3_out, r4_out, r5_out;
	logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
	logic r2_stall, r3_stall, r4_stall, r5_stall, out_stall;

	logic  valid_s11;
	proj_t proj_s11;
	logic  adv_s11;

	prp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// part yaw: (h, depth) -> (ox + px, oz)
	always_comb begin
		r1_in.u     = cfg.half_size;
		r1_in.v     = coord_t'(point.depth_offset);
		r1_in.off_u = coord_t'(point.point_x);
		r1_in.off_v = '0;
		r1_in.k0    = coord_t'(point.point_y);
		r1_in.k1    = coord_t'(point.point_z);
	end

	prp_rot u_rot_part_yaw (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (point_valid),
		.feed_stall (point_stall),
		.feed       (r1_in),
		.trig       (cfg.part_yaw),
		.res_valid  (r1_valid),
		.res_stall  (r2_stall),
		.res        (r1_out)
	);

	// part pitch: (h, oz) -> (oy + py, oz + pz)
	always_comb begin
		r2_in.u     = cfg.half_size;
		r2_in.v     = r1_out.v;
		r2_in.off_u = r1_out.k0;
		r2_in.off_v = r1_out.k1;
		r2_in.k0    = r1_out.u;
		r2_in.k1    = '0;
	end

	prp_rot u_rot_part_pitch (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (r1_valid),
		.feed_stall (r2_stall),
		.feed       (r2_in),
		.trig       (cfg.part_pitch),
		.res_valid  (r2_valid),
		.res_stall  (r3_stall),
		.res        (r2_out)
	);

	// view yaw on (X, Z)
	always_comb begin
		r3_in.u     = r2_out.k0;
		r3_in.v     = r2_out.v;
		r3_in.off_u = '0;
		r3_in.off_v = '0;
		r3_in.k0    = r2_out.u;
		r3_in.k1    = '0;
	end

	prp_rot u_rot_view_yaw (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (r2_valid),
		.feed_stall (r3_stall),
		.feed       (r3_in),
		.trig       (cfg.view_yaw),
		.res_valid  (r3_valid),
		.res_stall  (r4_stall),
		.res        (r3_out)
	);

	// view pitch on (Y, Z)
	always_comb begin
		r4_in.u     = r3_out.k0;
		r4_in.v     = r3_out.v;
		r4_in.off_u = '0;
		r4_in.off_v = '0;
		r4_in.k0    = r3_out.u;
		r4_in.k1    = '0;
	end

	prp_rot u_rot_view_pitch (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (r3_valid),
		.feed_stall (r4_stall),
		.feed       (r4_in),
		.trig       (cfg.view_pitch),
		.res_valid  (r4_valid),
		.res_stall  (r5_stall),
		.res        (r4_out)
	);

	// view roll on (X, Y)
	always_comb begin
		r5_in.u     = r4_out.k0;
		r5_in.v     = r4_out.u;
		r5_in.off_u = '0;
		r5_in.off_v = '0;
		r5_in.k0    = '0;
		r5_in.k1    = '0;
	end

	prp_rot u_rot_view_roll (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (r4_valid),
		.feed_stall (r5_stall),
		.feed       (r5_in),
		.trig       (cfg.view_roll),
		.res_valid  (r5_valid),
		.res_stall  (out_stall),
		.res        (r5_out)
	);

	assign adv_s11 = !valid_s11 || !proj_stall;
	assign out_stall = !adv_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else if (adv_s11) begin
			valid_s11 <= r5_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s11) begin
			proj_s11.proj_x <= sat_field(diff_t'(r5_out.u) - diff_t'(cfg.origin_x));
			proj_s11.proj_y <= sat_field(diff_t'(r5_out.v) - diff_t'(cfg.origin_y));
		end
	end

	assign proj_valid = valid_s11;
	assign proj = proj_s11;

endmodule

// File: src/prp_chk.sv
`include "assert_macros.svh"

module prp_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           point_valid,
	input logic           point_stall,
	input logic           proj_valid,
	input logic           proj_stall,
	input prp_pkg::proj_t proj
);
	import prp_pkg::*;

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic [CNT_W-1:0] inflight_q;
	logic in_beat;
	logic out_beat;

	assign in_beat  = point_valid && !point_stall;
	assign out_beat = proj_valid && !proj_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_beat && !out_beat) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (!in_beat && out_beat) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	// an empty output register never pushes back on the input
	`ASSERT_IMPLIES(a_idle_out_no_stall, clk, arst_n, !proj_valid, !point_stall)

	// every output beat belongs to an accepted point
	`ASSERT_IMPLIES(a_no_invented_beat, clk, arst_n, proj_valid, inflight_q != '0)

	// a full pipe only takes a point when one leaves
	`ASSERT_IMPLIES(a_depth_bound, clk, arst_n, in_beat && (inflight_q == CNT_W'(PIPE_DEPTH)), out_beat)

	`ASSERT_NEXT(a_stalled_hold, clk, arst_n, proj_valid && proj_stall, proj_valid && $stable(proj))

endmodule

bind point_rotate_project_unit prp_chk u_prp_chk (.*);

// File: bench/point_rotate_project_unit_tb.sv
`timescale 1ns / 1ps

module point_rotate_project_unit_tb;
	import prp_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES     = 8;
	localparam int PHASE_ITEMS = 116;
	localparam int HOLD_LEN   = 80;

	class proj_scoreboard;
		logic signed [ANGLE_W-1:0] angle_deg [5];
		logic [SIZE_W-1:0] part_size;
		field_t origin_x;
		field_t origin_y;
		longint sine_q15 [0:90];
		proj_t pending [$];
		int errors;
		int checked;
		int noted;

		function new();
			longint unsigned x;
			longint unsigned t;
			longint s;
			for (int k = 0; k <= 90; k++) begin
				x = (longint'(k) * 64'd3373259426 + 64'd90) / 64'd180;
				t = x;
				s = longint'(x);
				for (int n = 1; n <= 8; n++) begin
					t = (t * x) >> 30;
					t = (t * x) >> 30;
					t = t / longint'((2 * n) * (2 * n + 1));
					if (n % 2 == 1) begin
						s = s - longint'(t);
					end else begin
						s = s + longint'(t);
					end
				end
				if (s < 0) begin
					s = 0;
				end
				sine_q15[k] = (s + (longint'(1) << 14)) >>> 15;
			end
			foreach (angle_deg[i]) angle_deg[i] = '0;
			part_size = '0;
			origin_x = '0;
			origin_y = '0;
			errors = 0;
			checked = 0;
			noted = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [FIELD_W-1:0] value);
			case (idx)
				CFG_VIEW_YAW, CFG_VIEW_PITCH, CFG_VIEW_ROLL, CFG_PART_YAW,
				CFG_PART_PITCH: begin
					angle_deg[int'(idx)] = value[ANGLE_W-1:0];
				end
				CFG_PART_SIZE: begin
					part_size = value[SIZE_W-1:0];
				end
				CFG_ORIGIN_X: begin
					origin_x = value;
				end
				default: begin
					origin_y = value;
				end
			endcase
		endfunction

		function longint sine_of(int a);
			if (a <= 90) return sine_q15[a];
			if (a <= 180) return sine_q15[180 - a];
			if (a <= 270) return -sine_q15[a - 180];
			return -sine_q15[360 - a];
		endfunction

		function void rotate(longint u, longint v, cfg_reg_t r, output longint ru,
				output longint rv);
			int a;
			longint s;
			longint c;
			a = int'(angle_deg[int'(r)]) % 360;
			if (a < 0) begin
				a = a + 360;
			end
			s = sine_of(a);
			c = sine_of((a + 90) % 360);
			ru = (u * c - v * s + (longint'(1) << 14)) >>> 15;
			rv = (u * s + v * c + (longint'(1) << 14)) >>> 15;
		endfunction

		function field_t clamp(longint v);
			if (v > 64'sd8388607) return field_t'(24'h7FFFFF);
			if (v < -64'sd8388608) return field_t'(24'h800000);
			return field_t'(v);
		endfunction

		function void note(point_t p);
			longint h;
			longint ox;
			longint oy;
			longint oz;
			longint xs;
			longint ys;
			longint zs;
			proj_t res;
			h = -(longint'(part_size) * 128);
			rotate(h, longint'(p.depth_offset), CFG_PART_YAW, ox, oz);
			rotate(h, oz, CFG_PART_PITCH, oy, oz);
			xs = ox + longint'(p.point_x);
			ys = oy + longint'(p.point_y);
			zs = oz + longint'(p.point_z);
			rotate(xs, zs, CFG_VIEW_YAW, xs, zs);
			rotate(ys, zs, CFG_VIEW_PITCH, ys, zs);
			rotate(xs, ys, CFG_VIEW_ROLL, xs, ys);
			res.proj_x = clamp(xs - longint'(origin_x));
			res.proj_y = clamp(ys - longint'(origin_y));
			pending.push_back(res);
			noted++;
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check(proj_t got);
			proj_t exp_res;
			checked++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected beat x=%h y=%h", got.proj_x, got.proj_y));
			end else begin
				exp_res = pending.pop_front();
				if (got.proj_x !== exp_res.proj_x) begin
					report($sformatf("proj_x got %h want %h", got.proj_x, exp_res.proj_x));
				end
				if (got.proj_y !== exp_res.proj_y) begin
					report($sformatf("proj_y got %h want %h", got.proj_y, exp_res.proj_y));
				end
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [FIELD_W-1:0] cfg_wdata;
	logic point_valid;
	logic point_stall;
	point_t point;
	logic proj_valid;
	logic proj_stall = 1'b0;
	proj_t proj;

	proj_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int idle_count = 0;
	int settings = 0;

	point_rotate_project_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.proj_valid(proj_valid),
		.proj_stall(proj_stall),
		.proj(proj)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			proj_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else begin
			proj_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && proj_valid && !proj_stall) begin
			sb.check(proj);
		end
	end

	always @(posedge clk) begin
		if ((point_valid && !point_stall) || (proj_valid && !proj_stall)) begin
			idle_count <= 0;
		end else begin
			idle_count <= idle_count + 1;
			if (idle_count >= IDLE_LIMIT) begin
				$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
				$display("[point_rotate_project_unit] ERROR");
				$finish;
			end
		end
	end

	function int pick_gap();
		int n;
		n = 0;
		while ($urandom_range(0, 99) < send_idle_pct && n < 40) n++;
		return n;
	endfunction

	function field_t rand_field(int kind);
		field_t f;
		case (kind)
			0: f = field_t'($signed($urandom_range(0, 4095) - 2048));
			1: begin
				case ($urandom_range(0, 3))
					0: f = field_t'(24'h7FFFFF);
					1: f = field_t'(24'h800000);
					2: f = field_t'(24'h000000);
					default: f = field_t'(24'hFFFFFF);
				endcase
			end
			default: f = field_t'($urandom);
		endcase
		return f;
	endfunction

	function point_t rand_point();
		point_t p;
		int kind;
		kind = $urandom_range(0, 3);
		p.point_x = rand_field(kind);
		p.point_y = rand_field(kind);
		p.point_z = rand_field(kind);
		p.depth_offset = rand_field(kind);
		return p;
	endfunction

	function logic [FIELD_W-1:0] rand_angle();
		logic [FIELD_W-1:0] w;
		int picks [11];
		picks = '{-512, -360, -270, -180, -90, 0, 90, 180, 270, 360, 511};
		w = FIELD_W'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			w[ANGLE_W-1:0] = ANGLE_W'(picks[$urandom_range(0, 10)]);
		end
		return w;
	endfunction

	task send_point(point_t p, int gap);
		repeat (gap) begin
			@(negedge clk);
			point_valid <= 1'b0;
		end
		@(negedge clk);
		point_valid <= 1'b1;
		point <= p;
		do @(posedge clk); while (point_stall);
		sb.note(p);
	endtask

	task settle();
		@(negedge clk);
		point_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task write_reg(cfg_reg_t r, logic [FIELD_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_wdata <= v;
		sb.set_reg(r, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task program_all(logic [FIELD_W-1:0] vyaw, logic [FIELD_W-1:0] vpitch,
			logic [FIELD_W-1:0] vroll, logic [FIELD_W-1:0] pyaw,
			logic [FIELD_W-1:0] ppitch, logic [FIELD_W-1:0] size,
			logic [FIELD_W-1:0] ox, logic [FIELD_W-1:0] oy);
		settle();
		write_reg(CFG_VIEW_YAW, vyaw);
		write_reg(CFG_VIEW_PITCH, vpitch);
		write_reg(CFG_VIEW_ROLL, vroll);
		write_reg(CFG_PART_YAW, pyaw);
		write_reg(CFG_PART_PITCH, ppitch);
		write_reg(CFG_PART_SIZE, size);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		settings++;
	endtask

	task send_directed();
		point_t p;
		p = '0;
		send_point(p, 0);
		p = {4{field_t'(24'h7FFFFF)}};
		send_point(p, 0);
		p = {4{field_t'(24'h800000)}};
		send_point(p, 0);
		p = {field_t'(24'h7FFFFF), field_t'(24'h800000), field_t'(24'h7FFFFF),
			field_t'(24'h800000)};
		send_point(p, 0);
		p = {field_t'(24'h800000), field_t'(24'h7FFFFF), field_t'(24'h800000),
			field_t'(24'h7FFFFF)};
		send_point(p, 0);
		p = {4{field_t'(24'h000001)}};
		send_point(p, 0);
		p = {4{field_t'(24'hFFFFFF)}};
		send_point(p, 0);
		p = {field_t'(24'h555555), field_t'(24'hAAAAAA), field_t'(24'h555555),
			field_t'(24'hAAAAAA)};
		send_point(p, 0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		point_valid = 1'b0;
		point = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset, then mostly right angles, extreme sizes and saturating origins
		send_directed();
		program_all(24'd90, 24'd180, 24'd270, 24'h3FFD2E, 24'd90, 24'd1023,
			24'h800000, 24'h7FFFFF);
		send_directed();
		program_all(24'hFFFE00, 24'd511, 24'hFFFE98, 24'd360, 24'hABC00D, 24'hFFFC00,
			24'h7FFFFF, 24'h800000);
		send_directed();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: program_all(24'd360, 24'd360, 24'd360, 24'd360, 24'd360, 24'd1023,
					24'h800000, 24'h800000);
				1: program_all(24'hFFFE00, 24'hFFFE00, 24'hFFFE00, 24'hFFFE00,
					24'hFFFE00, 24'd0, 24'h7FFFFF, 24'h7FFFFF);
				default: program_all(rand_angle(), rand_angle(), rand_angle(),
					rand_angle(), rand_angle(), FIELD_W'($urandom), FIELD_W'($urandom),
					FIELD_W'($urandom));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 59; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 59; end
				default: begin send_idle_pct = 12; stall_pct = 12; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 4 && i == 20) begin
					hold_cycles = HOLD_LEN;
				end
				if (ph == 2 && i == 50) begin
					settle();
				end
				send_point(rand_point(), pick_gap());
			end
		end

		send_idle_pct = 0;
		stall_pct = 0;
		settle();
		repeat (20) @(posedge clk);
		if (sb.pending.size() != 0) begin
			sb.report($sformatf("%0d results never came", sb.pending.size()));
		end
		$display("Covered %0d points (%0d results checked) over %0d register settings,",
			sb.noted, sb.checked, settings + 1);
		$display("with sender gaps, receiver stalls, a long output hold and full drains.");
		if (sb.errors == 0) begin
			$display("[point_rotate_project_unit] OK");
		end else begin
			$display("[point_rotate_project_unit] ERROR");
		end
		$finish;
	end

endmodule
